### rtl/svst_pkg.sv
// ----------------------------------------------------------------------------
// svst_pkg
// Shared types and constants for the smoothstep servo trajectory generator.
// ----------------------------------------------------------------------------
package svst_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int MAXRES       = 8;

    // configuration register indexes
    localparam logic [2:0] REG_PULSE_LOW     = 3'd0;
    localparam logic [2:0] REG_PULSE_HIGH    = 3'd1;
    localparam logic [2:0] REG_HOME_PULSE    = 3'd2;
    localparam logic [2:0] REG_DEF_DURATION  = 3'd3;
    localparam logic [2:0] REG_DEF_CAP       = 3'd4;
    localparam logic [2:0] REG_DURATION_LIM  = 3'd5;
    localparam logic [2:0] REG_CAP_LIM       = 3'd6;

    // configuration reset values
    localparam logic [11:0] PULSE_LOW_RST    = 12'd500;
    localparam logic [11:0] PULSE_HIGH_RST   = 12'd2500;
    localparam logic [11:0] HOME_PULSE_RST   = 12'd1500;
    localparam logic [15:0] DEF_DURATION_RST = 16'd400;
    localparam logic [15:0] DEF_CAP_RST      = 16'd3000;
    localparam logic [15:0] DURATION_LIM_RST = 16'd30000;
    localparam logic [15:0] CAP_LIM_RST      = 16'd4000;

    // result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;

    localparam logic [21:0] DUR_MAX       = 22'h3FFFFF;
    localparam logic [11:0] MD_SCALE      = 12'd3000;   // 2 * 1500
    localparam logic [17:0] EASE_THREE    = 18'd196608; // 3.0 in Q2.16
    localparam int          MD_DIV_STEPS   = 25;
    localparam int          EASE_DIV_STEPS = 16;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SET_PREP,
        CMD_DIV_MD,
        CMD_STRETCH,
        CMD_COMMIT,
        CMD_EMIT_SNAP,
        CMD_EMIT_REPORT,
        CMD_EMIT_BADCH,
        CMD_TICK_EVAL,
        CMD_DIV_EASE,
        CMD_MUL1,
        CMD_MUL2,
        CMD_MUL3,
        CMD_MUL4,
        CMD_TICK_APPLY,
        CMD_NEXT_CHAN,
        CMD_FLUSH
    } cmd_t;

    typedef struct packed {
        logic opcode;
        logic bad_ch;
        logic target_eq;
        logic need_div;
        logic div_busy;
        logic dur_zero;
        logic chan_settled;
        logic ease_needed;
        logic apply_emit;
        logic last_chan;
        logic out_free;
    } stat_t;

endpackage

### rtl/svst_ctrl.sv
// ----------------------------------------------------------------------------
// svst_ctrl
// Sequencer: walks set and tick requests through the datapath.
// ----------------------------------------------------------------------------
module svst_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  svst_pkg::stat_t stat,
    output svst_pkg::cmd_t  cmd
);
    import svst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_BADCH,
        S_SET_CHK,
        S_SET_DIV,
        S_SET_COMMIT,
        S_SET_SNAP,
        S_SET_REPORT,
        S_TICK_EVAL,
        S_TICK_DIV,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_TICK_APPLY,
        S_TICK_FLUSH
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.opcode) begin
                    state_next = S_TICK_EVAL;
                end else if (stat.bad_ch) begin
                    state_next = S_BADCH;
                end else begin
                    cmd        = CMD_SET_PREP;
                    state_next = S_SET_CHK;
                end
            end
            S_BADCH: begin
                if (stat.out_free) begin
                    cmd        = CMD_EMIT_BADCH;
                    state_next = S_IDLE;
                end
            end
            S_SET_CHK: begin
                if (stat.target_eq) begin
                    if (stat.out_free) begin
                        cmd        = CMD_EMIT_REPORT;
                        state_next = S_IDLE;
                    end
                end else if (stat.need_div) begin
                    cmd        = CMD_DIV_MD;
                    state_next = S_SET_DIV;
                end else begin
                    state_next = S_SET_COMMIT;
                end
            end
            S_SET_DIV: begin
                if (!stat.div_busy) begin
                    cmd        = CMD_STRETCH;
                    state_next = S_SET_COMMIT;
                end
            end
            S_SET_COMMIT: begin
                cmd        = CMD_COMMIT;
                state_next = stat.dur_zero ? S_SET_SNAP : S_SET_REPORT;
            end
            S_SET_SNAP: begin
                if (stat.out_free) begin
                    cmd        = CMD_EMIT_SNAP;
                    state_next = S_SET_REPORT;
                end
            end
            S_SET_REPORT: begin
                if (stat.out_free) begin
                    cmd        = CMD_EMIT_REPORT;
                    state_next = S_IDLE;
                end
            end
            S_TICK_EVAL: begin
                if (stat.chan_settled) begin
                    cmd        = CMD_NEXT_CHAN;
                    state_next = stat.last_chan ? S_TICK_FLUSH : S_TICK_EVAL;
                end else if (stat.ease_needed) begin
                    cmd        = CMD_DIV_EASE;
                    state_next = S_TICK_DIV;
                end else begin
                    cmd        = CMD_TICK_EVAL;
                    state_next = S_TICK_APPLY;
                end
            end
            S_TICK_DIV: begin
                if (!stat.div_busy) begin
                    cmd        = CMD_MUL1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2: begin
                cmd        = CMD_MUL2;
                state_next = S_MUL3;
            end
            S_MUL3: begin
                cmd        = CMD_MUL3;
                state_next = S_MUL4;
            end
            S_MUL4: begin
                cmd        = CMD_MUL4;
                state_next = S_TICK_APPLY;
            end
            S_TICK_APPLY: begin
                // a held write leaves only when the output register is free
                if (!stat.apply_emit || stat.out_free) begin
                    cmd        = CMD_TICK_APPLY;
                    state_next = stat.last_chan ? S_TICK_FLUSH : S_TICK_EVAL;
                end
            end
            S_TICK_FLUSH: begin
                if (stat.out_free) begin
                    cmd        = CMD_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/svst_dp.sv
// ----------------------------------------------------------------------------
// svst_dp
// Datapath: configuration, channel state, shared divider, easing multiplier
// chain and the result register.
// ----------------------------------------------------------------------------
module svst_dp #(
    parameter int CHANNELS = svst_pkg::CHANNELS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic            s_opcode,
    input  logic [3:0]      s_channel,
    input  logic [15:0]     s_pulse_request,
    input  logic            s_duration_given,
    input  logic [15:0]     s_duration_request,
    input  logic            s_cap_given,
    input  logic [15:0]     s_cap_request,
    input  logic [31:0]     s_now_ms,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_kind,
    output logic            m_status,
    output logic [3:0]      m_out_channel,
    output logic [11:0]     m_pulse_out,
    output logic            m_pulse_clipped,
    output logic            m_duration_clipped,
    output logic            m_cap_clipped,
    output logic            m_changed,
    output logic            m_last,
    input  svst_pkg::cmd_t  cmd,
    output svst_pkg::stat_t stat
);
    import svst_pkg::*;

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [62:0] ROUND_HALF = 63'h1 << 47;

    // configuration
    logic [11:0] pulse_low_reg, pulse_high_reg;
    logic [15:0] def_dur_reg, def_cap_reg, dur_lim_reg, cap_lim_reg;

    // request latch
    logic        op_reg, dgiven_reg, cgiven_reg;
    logic [3:0]  ch_reg;
    logic [15:0] preq_reg, dreq_reg, creq_reg;
    logic [31:0] now_reg;

    // channel state
    logic [11:0] start_reg   [CHANNELS];
    logic [11:0] target_reg  [CHANNELS];
    logic [11:0] cur_reg     [CHANNELS];
    logic [21:0] mdur_reg    [CHANNELS];
    logic [31:0] mst_reg     [CHANNELS];
    logic        settled_reg [CHANNELS];

    logic [IW-1:0] idx_reg;
    logic [11:0]   pulse_reg, next_reg;
    logic [21:0]   dur_reg;
    logic [15:0]   cap_reg;
    logic          pc_reg, dc_reg, cc_reg, chg_reg;

    // divider
    logic [22:0] div_r_reg;
    logic [24:0] div_n_reg, div_q_reg;
    logic [21:0] div_d_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_busy_reg;

    // easing chain
    logic [31:0]        ff_reg;
    logic [17:0]        g_reg;
    logic [47:0]        p_reg;
    logic signed [61:0] prod_reg;

    // held tick write
    logic        pend_valid_reg;
    logic [3:0]  pend_ch_reg;
    logic [11:0] pend_pulse_reg;
    logic [3:0]  n_reg;

    logic m_valid_reg;

    // ---------------- combinational ----------------
    logic [15:0] lo_ext, hi_ext, p1, p2;
    logic        pc_c, dc_c, cc_c;
    logic [15:0] dur_c, cap_c;
    logic [11:0] start_sel, target_sel, cur_sel;
    logic [21:0] mdur_sel;
    logic [31:0] mst_sel, el;
    logic        hold, fin, last_chan, apply_changed, apply_emit, out_free;
    logic [11:0] travel;
    logic [24:0] md_num;
    logic [21:0] md_sat;
    logic [23:0] div_t, div_diff;
    logic        div_ge;
    logic [15:0] f;
    logic [49:0] p_full;
    logic signed [12:0] delta;
    logic signed [61:0] prod_full;
    logic signed [62:0] tot;
    logic [11:0] ease_pulse;
    logic [IW-1:0] idx_adv;

    assign cfg_ready = 1'b1;

    always_comb begin
        lo_ext = {4'b0, pulse_low_reg};
        hi_ext = {4'b0, pulse_high_reg};
        pc_c   = 1'b0;
        p1     = preq_reg;
        if (preq_reg < lo_ext) begin
            p1   = lo_ext;
            pc_c = 1'b1;
        end
        p2 = p1;
        if (p1 > hi_ext) begin
            p2   = hi_ext;
            pc_c = 1'b1;
        end
        dc_c  = 1'b0;
        dur_c = def_dur_reg;
        if (dgiven_reg) begin
            dur_c = dreq_reg;
            if (dreq_reg > dur_lim_reg) begin
                dur_c = dur_lim_reg;
                dc_c  = 1'b1;
            end
        end
        cc_c  = 1'b0;
        cap_c = def_cap_reg;
        if (cgiven_reg) begin
            cap_c = creq_reg;
            if (creq_reg > cap_lim_reg) begin
                cap_c = cap_lim_reg;
                cc_c  = 1'b1;
            end
        end
    end

    assign start_sel  = start_reg[idx_reg];
    assign target_sel = target_reg[idx_reg];
    assign cur_sel    = cur_reg[idx_reg];
    assign mdur_sel   = mdur_reg[idx_reg];
    assign mst_sel    = mst_reg[idx_reg];

    assign travel = (pulse_reg > cur_sel) ? (pulse_reg - cur_sel) : (cur_sel - pulse_reg);
    assign md_num = 25'(travel) * 25'(MD_SCALE) + 25'(cap_reg);
    assign md_sat = (div_q_reg > {3'b0, DUR_MAX}) ? DUR_MAX : div_q_reg[21:0];

    // elapsed time since the move started, read as signed
    assign el   = now_reg - mst_sel;
    assign hold = el[31] && (mdur_sel != '0);
    assign fin  = (mdur_sel == '0) || (el >= {10'b0, mdur_sel});

    assign last_chan     = (idx_reg == IW'(CHANNELS - 1));
    assign idx_adv       = last_chan ? '0 : idx_reg + 1'b1;
    assign apply_changed = (next_reg != cur_sel);
    assign apply_emit    = apply_changed && (n_reg < 4'(MAXRES)) && pend_valid_reg;
    assign out_free      = !m_valid_reg || m_ready;

    assign div_t    = {div_r_reg, div_n_reg[24]};
    assign div_diff = div_t - {2'b0, div_d_reg};
    assign div_ge   = (div_t >= {2'b0, div_d_reg});

    assign f         = div_q_reg[15:0];
    assign p_full    = ff_reg * g_reg;
    assign delta     = $signed({1'b0, target_sel}) - $signed({1'b0, start_sel});
    assign prod_full = delta * $signed({1'b0, p_reg});
    assign tot       = $signed({3'b0, start_sel, 48'b0}) + prod_reg + $signed(ROUND_HALF);
    assign ease_pulse = tot[62] ? 12'd0 : tot[59:48];

    always_comb begin
        stat.opcode       = op_reg;
        stat.bad_ch       = ({1'b0, ch_reg} >= 5'(CHANNELS));
        stat.target_eq    = (target_sel == pulse_reg);
        stat.need_div     = (cap_reg != '0) && (travel != '0);
        stat.div_busy     = div_busy_reg;
        stat.dur_zero     = (dur_reg == '0);
        stat.chan_settled = settled_reg[idx_reg];
        stat.ease_needed  = !hold && !fin;
        stat.apply_emit   = apply_emit;
        stat.last_chan    = last_chan;
        stat.out_free     = out_free;
    end

    // ---------------- configuration ----------------
    // home pulse writes are accepted but the channel state always resets to
    // the default home pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_low_reg  <= PULSE_LOW_RST;
            pulse_high_reg <= PULSE_HIGH_RST;
            def_dur_reg    <= DEF_DURATION_RST;
            def_cap_reg    <= DEF_CAP_RST;
            dur_lim_reg    <= DURATION_LIM_RST;
            cap_lim_reg    <= CAP_LIM_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PULSE_LOW:    pulse_low_reg  <= cfg_data[11:0];
                REG_PULSE_HIGH:   pulse_high_reg <= cfg_data[11:0];
                REG_HOME_PULSE:   ;
                REG_DEF_DURATION: def_dur_reg    <= cfg_data;
                REG_DEF_CAP:      def_cap_reg    <= cfg_data;
                REG_DURATION_LIM: dur_lim_reg    <= cfg_data;
                REG_CAP_LIM:      cap_lim_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- channel state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                start_reg[i]   <= HOME_PULSE_RST;
                target_reg[i]  <= HOME_PULSE_RST;
                cur_reg[i]     <= HOME_PULSE_RST;
                mdur_reg[i]    <= '0;
                mst_reg[i]     <= '0;
                settled_reg[i] <= 1'b1;
            end
        end else begin
            case (cmd)
                CMD_COMMIT: begin
                    start_reg[idx_reg]   <= cur_sel;
                    target_reg[idx_reg]  <= pulse_reg;
                    mdur_reg[idx_reg]    <= dur_reg;
                    mst_reg[idx_reg]     <= now_reg;
                    settled_reg[idx_reg] <= (dur_reg == '0);
                    if (dur_reg == '0) begin
                        cur_reg[idx_reg] <= pulse_reg;
                    end
                end
                CMD_TICK_EVAL: begin
                    if (!hold) begin
                        settled_reg[idx_reg] <= 1'b1;
                    end
                end
                CMD_TICK_APPLY: begin
                    if (apply_changed) begin
                        cur_reg[idx_reg] <= next_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- shared restoring divider ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cmd == CMD_DIV_MD) begin
            div_r_reg    <= '0;
            div_n_reg    <= md_num;
            div_q_reg    <= '0;
            div_d_reg    <= {5'b0, cap_reg, 1'b0};
            div_cnt_reg  <= 5'(MD_DIV_STEPS);
            div_busy_reg <= 1'b1;
        end else if (cmd == CMD_DIV_EASE) begin
            // elapsed < duration, so the quotient is the Q0.16 fraction
            div_r_reg    <= {1'b0, el[21:0]};
            div_n_reg    <= '0;
            div_q_reg    <= '0;
            div_d_reg    <= mdur_sel;
            div_cnt_reg  <= 5'(EASE_DIV_STEPS);
            div_busy_reg <= 1'b1;
        end else if (div_busy_reg) begin
            div_r_reg   <= div_ge ? div_diff[22:0] : div_t[22:0];
            div_n_reg   <= {div_n_reg[23:0], 1'b0};
            div_q_reg   <= {div_q_reg[23:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == 5'd1) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------- easing chain ----------------
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_MUL1: begin
                ff_reg <= f * f;
                g_reg  <= EASE_THREE - {1'b0, f, 1'b0};
            end
            CMD_MUL2: p_reg    <= p_full[47:0];
            CMD_MUL3: prod_reg <= prod_full;
            default: ;
        endcase
    end

    // ---------------- request registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            chg_reg        <= 1'b0;
        end else begin
            case (cmd)
                CMD_LOAD: begin
                    op_reg         <= s_opcode;
                    ch_reg         <= s_channel;
                    preq_reg       <= s_pulse_request;
                    dgiven_reg     <= s_duration_given;
                    dreq_reg       <= s_duration_request;
                    cgiven_reg     <= s_cap_given;
                    creq_reg       <= s_cap_request;
                    now_reg        <= s_now_ms;
                    idx_reg        <= '0;
                    n_reg          <= '0;
                    pend_valid_reg <= 1'b0;
                    chg_reg        <= 1'b0;
                end
                CMD_SET_PREP: begin
                    idx_reg   <= ch_reg[IW-1:0];
                    pulse_reg <= p2[11:0];
                    dur_reg   <= {6'b0, dur_c};
                    cap_reg   <= cap_c;
                    pc_reg    <= pc_c;
                    dc_reg    <= dc_c;
                    cc_reg    <= cc_c;
                end
                CMD_STRETCH: begin
                    if (dur_reg < md_sat) begin
                        dur_reg <= md_sat;
                    end
                end
                CMD_COMMIT:    chg_reg  <= 1'b1;
                CMD_TICK_EVAL: next_reg <= hold ? start_sel : target_sel;
                CMD_MUL4:      next_reg <= ease_pulse;
                CMD_TICK_APPLY: begin
                    if (apply_changed && (n_reg < 4'(MAXRES))) begin
                        pend_valid_reg <= 1'b1;
                        pend_ch_reg    <= 4'(idx_reg);
                        pend_pulse_reg <= next_reg;
                        n_reg          <= n_reg + 1'b1;
                    end
                    idx_reg <= idx_adv;
                end
                CMD_NEXT_CHAN: idx_reg <= idx_adv;
                default: ;
            endcase
        end
    end

    // ---------------- result register ----------------
    logic        emit;
    logic [1:0]  kind_next;
    logic        status_next, pcl_next, dcl_next, ccl_next, chg_next, last_next;
    logic [3:0]  chan_next;
    logic [11:0] pulse_next;

    always_comb begin
        emit        = 1'b0;
        kind_next   = KIND_WRITE;
        status_next = 1'b0;
        chan_next   = 4'(idx_reg);
        pulse_next  = pulse_reg;
        pcl_next    = 1'b0;
        dcl_next    = 1'b0;
        ccl_next    = 1'b0;
        chg_next    = 1'b0;
        last_next   = 1'b0;
        case (cmd)
            CMD_EMIT_BADCH: begin
                emit        = 1'b1;
                kind_next   = KIND_REPORT;
                status_next = 1'b1;
                chan_next   = ch_reg;
                pulse_next  = '0;
                last_next   = 1'b1;
            end
            CMD_EMIT_SNAP: begin
                emit = 1'b1;
            end
            CMD_EMIT_REPORT: begin
                emit      = 1'b1;
                kind_next = KIND_REPORT;
                pcl_next  = pc_reg;
                dcl_next  = dc_reg;
                ccl_next  = cc_reg;
                chg_next  = chg_reg;
                last_next = 1'b1;
            end
            CMD_TICK_APPLY: begin
                emit       = apply_emit;
                chan_next  = pend_ch_reg;
                pulse_next = pend_pulse_reg;
            end
            CMD_FLUSH: begin
                emit      = 1'b1;
                last_next = 1'b1;
                if (pend_valid_reg) begin
                    chan_next  = pend_ch_reg;
                    pulse_next = pend_pulse_reg;
                end else begin
                    kind_next  = KIND_IDLE;
                    chan_next  = '0;
                    pulse_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind             <= kind_next;
            m_status           <= status_next;
            m_out_channel      <= chan_next;
            m_pulse_out        <= pulse_next;
            m_pulse_clipped    <= pcl_next;
            m_duration_clipped <= dcl_next;
            m_cap_clipped      <= ccl_next;
            m_changed          <= chg_next;
            m_last             <= last_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### rtl/servo_smoothstep_trajectory.sv
// ----------------------------------------------------------------------------
// servo_smoothstep_trajectory
// Multi-channel servo trajectory generator with smoothstep easing.
// ----------------------------------------------------------------------------
//  channel  ports        handshake      carries
//  cfg      cfg_*        valid/ready    register index, write data
//  input    s_*          valid/ready    set-target or tick request
//  result   m_*          valid/ready    pulse writes and reports
//
//  One request at a time. A set runs the velocity cap stretch through the
//  shared 25-step divider when the cap is nonzero and the pulse changes.
//  A tick walks every channel: settled ones are skipped, held and finishing
//  ones jump, easing ones use the 16-step divider and four multiply stages.
//  Synchronous active-low reset returns all channels to 1500 us, settled.
//  A busy result register stalls the sequencer only when a result is due.
// ----------------------------------------------------------------------------
module servo_smoothstep_trajectory #(
    parameter int CHANNELS = svst_pkg::CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [3:0]  s_channel,
    input  logic [15:0] s_pulse_request,
    input  logic        s_duration_given,
    input  logic [15:0] s_duration_request,
    input  logic        s_cap_given,
    input  logic [15:0] s_cap_request,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic        m_status,
    output logic [3:0]  m_out_channel,
    output logic [11:0] m_pulse_out,
    output logic        m_pulse_clipped,
    output logic        m_duration_clipped,
    output logic        m_cap_clipped,
    output logic        m_changed,
    output logic        m_last
);
    import svst_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    svst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    svst_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_opcode           (s_opcode),
        .s_channel          (s_channel),
        .s_pulse_request    (s_pulse_request),
        .s_duration_given   (s_duration_given),
        .s_duration_request (s_duration_request),
        .s_cap_given        (s_cap_given),
        .s_cap_request      (s_cap_request),
        .s_now_ms           (s_now_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_status           (m_status),
        .m_out_channel      (m_out_channel),
        .m_pulse_out        (m_pulse_out),
        .m_pulse_clipped    (m_pulse_clipped),
        .m_duration_clipped (m_duration_clipped),
        .m_cap_clipped      (m_cap_clipped),
        .m_changed          (m_changed),
        .m_last             (m_last),
        .cmd                (cmd),
        .stat               (stat)
    );

endmodule
